[rtl/gcol_pkg.sv]
// Shared types and codes for the grid cell occupancy list.
// Used by gcol_ctrl, gcol_dp and grid_cell_occupancy_list_top; no dependencies.
`default_nettype none

package gcol_pkg;

    // default list depth
    localparam int DEPTH_DEF = 64;

    // one stored cell: x, y, z packed
    localparam int CELL_W = 48;

    // request operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // request word
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
    } req_t;

    // result word
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] entry_count;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       clear;
        logic       issue;
        logic       add_wr;
        logic       shift_wr;
        logic       fill_dec;
        logic       rsp_load;
        logic [1:0] rsp_status;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       match;
        logic       more;
        logic       pend;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/grid_cell_occupancy_list_top.sv]
// Add: latch, then append the cell or report full. An unused code reports ok at once.
// Query: scan until a match or the end. Remove: scan, then shift later entries down.
// Throughput: one word at a time, set by the one-entry-per-cycle scan and shift;
// the next word can be taken at the edge that takes the result.
// Reset: asynchronous, active low; list holds only the origin cell, count one.
// Results are strobed by done for one cycle and cannot be stalled.
`default_nettype none

module grid_cell_occupancy_list_top
    import gcol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    gcol_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // memory and counters
    gcol_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

[rtl/gcol_ctrl.sv]
// Controller state machine for the grid cell occupancy list.
// Depends on gcol_pkg; drives the datapath gcol_dp through dp_cmd_t.
`default_nettype none

module gcol_ctrl
    import gcol_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire req_t     req,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.latch = 1'b1;
                    case (req.cmd)
                        OP_ADD:
                        begin
                            busy_next  = 1'b1;
                            state_next = S_ADD;
                        end
                        OP_QUERY, OP_REMOVE:
                        begin
                            cmd.clear  = 1'b1;
                            busy_next  = 1'b1;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            // unused code: no change, report ok at once
                            cmd.rsp_load   = 1'b1;
                            cmd.rsp_status = ST_OK;
                            done_next      = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.rsp_load = 1'b1;
                if (stat.full)
                begin
                    cmd.rsp_status = ST_FULL;
                end
                else
                begin
                    cmd.add_wr     = 1'b1;
                    cmd.rsp_status = ST_OK;
                end
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.op == OP_REMOVE)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_OK;
                        done_next      = 1'b1;
                        busy_next      = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
                else if (!stat.more && !stat.pend)
                begin
                    cmd.rsp_load   = 1'b1;
                    cmd.rsp_status = ST_MISS;
                    done_next      = 1'b1;
                    busy_next      = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.issue = stat.more;
                end
            end
            S_SHIFT:
            begin
                // read entry i while entry i-1 is written back one slot down
                cmd.issue    = stat.more;
                cmd.shift_wr = stat.pend;
                if (!stat.more && !stat.pend)
                begin
                    cmd.fill_dec   = 1'b1;
                    cmd.rsp_load   = 1'b1;
                    cmd.rsp_status = ST_OK;
                    done_next      = 1'b1;
                    busy_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // a result strobe leaves the block ready for the next word
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // busy only drops together with a result
    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("busy dropped without result");

    // controller only works while busy
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> busy_reg)
        else $error("active state while not busy");

endmodule

`default_nettype wire

[rtl/gcol_dp.sv]
// Datapath for the grid cell occupancy list: cell memory, fill level, scan index.
// Depends on gcol_pkg; commanded by gcol_ctrl.
`default_nettype none

module gcol_dp
    import gcol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire req_t    req,
    input  wire dp_cmd_t cmd,
    output dp_stat_t     stat,
    output rsp_t         rsp
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CELL_W-1:0] mem [DEPTH];

    req_t              req_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_vld_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic              rd_zero_reg;
    logic              origin_reg;
    rsp_t              rsp_reg;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] key;
    logic [CELL_W-1:0] rd_word;
    logic [CW+6:0]     count_ext;

    assign key = {req_reg.cell_x, req_reg.cell_y, req_reg.cell_z};

    // slot zero reads as the origin until it is first written
    assign rd_word = rd_zero_reg ? '0 : rd_data_reg;

    // status toward the controller
    assign stat.op    = req_reg.cmd;
    assign stat.full  = (fill_reg >= CW'(DEPTH));
    assign stat.more  = (idx_reg < fill_reg);
    assign stat.pend  = rd_vld_reg;
    assign stat.match = rd_vld_reg && (rd_word == key);

    // memory write select: append or shift down
    always_comb
    begin
        mem_we    = cmd.add_wr || (cmd.shift_wr && rd_vld_reg);
        mem_waddr = cmd.add_wr ? fill_reg[IW-1:0] : (rd_idx_reg - IW'(1));
        mem_wdata = cmd.add_wr ? key : rd_word;
    end

    // fill level and scan index
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.add_wr)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (cmd.clear)
        begin
            idx_next = '0;
        end
        else if (cmd.issue)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= CW'(1);
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            origin_reg <= 1'b1;
        end
        else
        begin
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= cmd.issue;
            if (mem_we && (mem_waddr == '0))
            begin
                origin_reg <= 1'b0;
            end
        end
    end

    // cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[idx_reg[IW-1:0]];
            rd_zero_reg <= origin_reg && (idx_reg == '0);
            rd_idx_reg  <= idx_reg[IW-1:0];
        end
    end

    // request and result words
    assign count_ext = {7'd0, fill_next};

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.status      <= cmd.rsp_status;
            rsp_reg.entry_count <= count_ext[6:0];
        end
    end

    assign rsp = rsp_reg;

    // fill level never passes the depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill level out of range");

    // a read issued is compared in the next cycle
    a_read_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> rd_vld_reg)
        else $error("read result lost");

    // shift never writes below slot zero
    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_wr && rd_vld_reg) |-> (rd_idx_reg != '0))
        else $error("shift write from slot zero");

endmodule

`default_nettype wire
